// ----- design/gge_pkg.sv -----
// shared types and constants for the generation engine
// no dependencies
`default_nettype none
package gge_pkg;
  localparam int PopSize = 8;
  localparam int StringBits = 8;
  localparam logic [31:0] LfsrTaps = 32'h80200003;
  localparam logic [31:0] SeedReset = 32'd1;
  localparam logic [15:0] XoverReset = 16'd45875;
  localparam logic [15:0] MutReset = 16'd66;
  localparam logic [1:0] REG_SEED = 2'd0;
  localparam logic [1:0] REG_XOVER = 2'd1;
  localparam logic [1:0] REG_MUT = 2'd2;
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [2:0] member_index;
    logic [7:0] member_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] member_slot;
    logic [7:0] member_bits;
    logic [3:0] member_fit;
    logic       all_ones;
    logic       last_member;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic fit_sum;
    logic sel_start;
    logic div_step;
    logic sel_step;
    logic xo_roll;
    logic xo_locus;
    logic xo_write;
    logic mut_step;
  } gge_cmd_t;

  typedef struct packed {
    logic sel_found;
    logic xo_hit;
  } gge_stat_t;

  function automatic logic [31:0] lfsr_step(input logic [31:0] v);
    lfsr_step = v[0] ? ((v >> 1) ^ LfsrTaps) : (v >> 1);
  endfunction

  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int b = 0; b < 8; b++) n = n + {3'd0, v[b]};
    return n;
  endfunction
endpackage
`default_nettype wire

// ----- design/gge_ctrl.sv -----
// sequencer for loads and generation phases
// depends on gge_pkg
`default_nettype none
module gge_ctrl #(
  parameter int POP_SIZE = gge_pkg::PopSize,
  parameter int IW = $clog2(POP_SIZE)
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic in_req,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire gge_pkg::gge_stat_t stat,
  output gge_pkg::gge_cmd_t cmd,
  output logic [IW-1:0] idx,
  output logic [IW-1:0] scan,
  output logic [2:0] bit_idx
);
  import gge_pkg::*;
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_SUM = 9'b000000010, S_SEL = 9'b000000100,
    S_DIV = 9'b000001000, S_SCAN = 9'b000010000, S_XR = 9'b000100000,
    S_XL = 9'b001000000, S_MUT = 9'b010000000, S_EMIT = 9'b100000000
  } state_t;
  state_t state, state_next;
  logic [IW-1:0] idx_next, scan_next;
  logic [2:0] bit_next;
  logic [IW:0] idx2;
  localparam logic [IW-1:0] LAST = IW'(POP_SIZE - 1);
  localparam bit ODD = (POP_SIZE % 2) == 1;

  assign idx2 = {1'b0, idx} + (IW+1)'(2);

  always_comb begin
    state_next = state; idx_next = idx; scan_next = scan; bit_next = bit_idx;
    cmd = '0; in_ready = 1'b0; out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req == REQ_LOAD) cmd.load = 1'b1;
          else begin
            state_next = S_SUM; idx_next = '0;
          end
        end
      end
      S_SUM: begin
        cmd.fit_sum = 1'b1;
        if (idx == LAST) begin
          state_next = S_SEL; idx_next = '0;
        end else idx_next = idx + 1'b1;
      end
      S_SEL: begin
        cmd.sel_start = 1'b1; state_next = S_DIV; bit_next = '0;
      end
      S_DIV: begin
        cmd.div_step = 1'b1; bit_next = bit_idx + 1'b1;
        if (bit_idx == 3'd7) begin
          state_next = S_SCAN; scan_next = '0;
        end
      end
      S_SCAN: begin
        cmd.sel_step = 1'b1;
        if (stat.sel_found || scan == LAST) begin
          if (idx == LAST) begin
            idx_next = '0;
            state_next = (ODD && POP_SIZE == 1) ? S_MUT : S_XR;
            if (ODD && LAST == '0) state_next = S_MUT;
          end else begin
            idx_next = idx + 1'b1; state_next = S_SEL;
          end
        end else scan_next = scan + 1'b1;
      end
      S_XR: begin
        if (ODD && idx == LAST) begin
          cmd.xo_write = 1'b1; state_next = S_MUT; idx_next = '0; bit_next = '0;
        end else begin
          cmd.xo_roll = 1'b1;
          if (stat.xo_hit) state_next = S_XL;
          else begin
            cmd.xo_write = 1'b1;
            if (idx2 > {1'b0, LAST}) begin
              state_next = S_MUT; idx_next = '0; bit_next = '0;
            end else idx_next = idx + IW'(2);
          end
        end
      end
      S_XL: begin
        cmd.xo_locus = 1'b1; cmd.xo_write = 1'b1;
        if (idx2 > {1'b0, LAST}) begin
          state_next = S_MUT; idx_next = '0; bit_next = '0;
        end else begin
          idx_next = idx + IW'(2); state_next = S_XR;
        end
      end
      S_MUT: begin
        cmd.mut_step = 1'b1; bit_next = bit_idx + 1'b1;
        if (bit_idx == 3'd7) begin
          if (idx == LAST) begin
            state_next = S_EMIT; idx_next = '0;
          end else idx_next = idx + 1'b1;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (idx == LAST) state_next = S_IDLE;
          else idx_next = idx + 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; idx <= '0; scan <= '0; bit_idx <= '0;
    end else begin
      state <= state_next; idx <= idx_next; scan <= scan_next; bit_idx <= bit_next;
    end
  end
endmodule
`default_nettype wire

// ----- design/gge_dp.sv -----
// population, fitness, selection, crossover, mutation and lfsr datapath
// depends on gge_pkg
`default_nettype none
module gge_dp #(
  parameter int POP_SIZE = gge_pkg::PopSize,
  parameter int IW = $clog2(POP_SIZE)
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire gge_pkg::gge_cmd_t cmd,
  output gge_pkg::gge_stat_t stat,
  input  wire logic [IW-1:0] idx,
  input  wire logic [IW-1:0] scan,
  input  wire logic [2:0] bit_idx,
  input  wire gge_pkg::in_item_t in_item,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  output gge_pkg::out_item_t out_item
);
  import gge_pkg::*;
  localparam int SW = $clog2(8 * POP_SIZE + 1);
  logic [7:0] pop [POP_SIZE];
  logic [3:0] fit [POP_SIZE];
  logic [IW-1:0] sel [POP_SIZE];
  logic [31:0] lfsr, seed_lfsr;
  logic [15:0] xo_thr, mut_thr;
  logic [SW-1:0] sum, acc, rmod, dvs;
  logic [31:0] nxt;
  logic [7:0] pa, pb, mask;
  logic [3:0] facc;
  logic mut_hit;
  logic [7:0] nextp [POP_SIZE];

  assign nxt = lfsr_step(lfsr);
  assign seed_lfsr = (cfg_data == '0) ? 32'd1 : cfg_data;
  assign facc = fit[scan];
  // zero fitness sum takes the draw modulo the population size
  assign dvs = (sum == '0) ? SW'(POP_SIZE) : sum;
  assign stat.sel_found = (sum == '0) || (rmod < acc + SW'(facc));
  assign stat.xo_hit = nxt[31:16] < xo_thr;
  assign mut_hit = nxt[31:16] < mut_thr;
  assign pa = pop[sel[idx]];
  assign pb = pop[sel[(idx == IW'(POP_SIZE - 1)) ? idx : idx + 1'b1]];
  assign mask = 8'((9'd1 << nxt[2:0]) - 9'd1);

  // remainder of the draw by the divisor: four restoring steps per cycle,
  // shifting in the 32-bit draw four bits at a time
  logic [31:0] dsrc;
  logic [SW:0] rem_w;
  always_comb begin
    rem_w = {1'b0, rmod};
    for (int k = 0; k < 4; k++) begin
      rem_w = {rem_w[SW-1:0], dsrc[31 - k]};
      if (rem_w >= {1'b0, dvs}) rem_w = rem_w - {1'b0, dvs};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= SeedReset; xo_thr <= XoverReset; mut_thr <= MutReset;
      for (int i = 0; i < POP_SIZE; i++) begin
        pop[i] <= '0; fit[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SEED: lfsr <= seed_lfsr;
          REG_XOVER: xo_thr <= cfg_data[15:0];
          REG_MUT: mut_thr <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.load && int'(in_item.member_index) < POP_SIZE)
        pop[IW'(in_item.member_index)] <= in_item.member_value;
      if (cmd.fit_sum) begin
        fit[idx] <= ones8(pop[idx]);
        sum <= (idx == '0) ? SW'(ones8(pop[idx])) : sum + SW'(ones8(pop[idx]));
      end
      if (cmd.sel_start) begin
        lfsr <= nxt; acc <= '0;
        dsrc <= nxt; rmod <= '0;
      end
      if (cmd.div_step) begin
        rmod <= rem_w[SW-1:0];
        dsrc <= {dsrc[27:0], 4'd0};
      end
      if (cmd.sel_step) begin
        acc <= acc + SW'(facc);
        sel[idx] <= (sum == '0) ? IW'(rmod) : scan;
      end
      if (cmd.xo_roll) lfsr <= nxt;
      if (cmd.xo_locus) lfsr <= nxt;
      if (cmd.mut_step) begin
        lfsr <= nxt;
        // at bit 0 a member takes its crossover child, bit 0 toggled on a hit; later bits toggle in place
        if (bit_idx == '0) pop[idx] <= nextp[idx] ^ {7'd0, mut_hit};
        else if (mut_hit) pop[idx][bit_idx] <= ~pop[idx][bit_idx];
      end
    end
  end

  // crossover writes into a staging copy, taken over member by member
  always_ff @(posedge clk) begin
    if (cmd.xo_write) begin
      if (cmd.xo_locus) begin
        nextp[idx] <= (pa & mask) | (pb & ~mask);
        if (idx != IW'(POP_SIZE - 1)) nextp[idx + 1'b1] <= (pb & mask) | (pa & ~mask);
      end else begin
        nextp[idx] <= pa;
        if (idx != IW'(POP_SIZE - 1)) nextp[idx + 1'b1] <= pb;
      end
    end
  end

  assign out_item.member_slot = 3'(idx);
  assign out_item.member_bits = pop[idx];
  assign out_item.member_fit = ones8(pop[idx]);
  assign out_item.all_ones = pop[idx] == 8'hFF;
  assign out_item.last_member = idx == IW'(POP_SIZE - 1);
endmodule
`default_nettype wire

// ----- design/genetic_generation_engine_core.sv -----
// one-max genetic generation engine, top level; depends on gge_pkg, gge_ctrl, gge_dp
// load item: accepted while idle, no result, the next item may follow at once
// run item: a fitness pass over all slots, then per slot a draw, the remainder steps and a
// scan; then crossover per pair of slots, mutation bit by bit, then POP result items one per
// cycle while out_ready is high; no new item is taken until the last result is out
// reset (synchronous, rst high): population and fitness zero, thresholds default, lfsr 1
`default_nettype none
module genetic_generation_engine_core #(
  parameter int POP_SIZE = gge_pkg::PopSize
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire gge_pkg::in_item_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output gge_pkg::out_item_t out_data,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  import gge_pkg::*;
  localparam int IW = $clog2(POP_SIZE);
  gge_cmd_t cmd;
  gge_stat_t stat;
  logic [IW-1:0] idx, scan;
  logic [2:0] bit_idx;

  // config is always taken
  assign cfg_ready = 1'b1;

  gge_ctrl #(.POP_SIZE(POP_SIZE)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_req(in_data.req_type),
    .out_valid, .out_ready, .stat, .cmd, .idx, .scan, .bit_idx
  );

  gge_dp #(.POP_SIZE(POP_SIZE)) u_dp (
    .clk, .rst, .cmd, .stat, .idx, .scan, .bit_idx, .in_item(in_data),
    .cfg_we(cfg_valid), .cfg_index, .cfg_data, .out_item(out_data)
  );
endmodule
`default_nettype wire

// ----- verif/gge_checker.sv -----
// result checker for the one-max generation engine: predicts and compares
// depends on gge_pkg; watches the input, result and config channels
`timescale 1ns / 100ps
`default_nettype none
module gge_checker (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  wire gge_pkg::in_item_t in_data,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  wire gge_pkg::out_item_t out_data,
  input  wire logic cfg_valid,
  input  wire logic cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  output int fail_count,
  output int pending_members
);
  import gge_pkg::*;

  logic [31:0] lfsr;
  logic [15:0] xover_th, mut_th;
  logic [7:0] pop [PopSize];
  out_item_t member_fifo [$];

  function automatic logic [31:0] next_draw();
    lfsr = lfsr[0] ? ((lfsr >> 1) ^ 32'h80200003) : (lfsr >> 1);
    return lfsr;
  endfunction

  function automatic logic [3:0] popcount8(logic [7:0] v);
    logic [3:0] n;
    n = 0;
    for (int b = 0; b < 8; b++) n += v[b];
    return n;
  endfunction

  task automatic run_generation();
    logic [3:0] fit [PopSize];
    int unsigned sel [PopSize];
    logic [7:0] nxt [PopSize];
    int unsigned sum, r, acc, locus;
    logic [7:0] pa, pb, mask;
    out_item_t m;
    sum = 0;
    for (int i = 0; i < PopSize; i++) begin
      fit[i] = popcount8(pop[i]);
      sum += fit[i];
    end
    for (int i = 0; i < PopSize; i++) begin
      r = next_draw();
      sel[i] = 0;
      if (sum == 0) begin
        sel[i] = r % PopSize;
      end else begin
        r = r % sum;
        acc = 0;
        for (int j = 0; j < PopSize; j++) begin
          acc += fit[j];
          if (r < acc) begin
            sel[i] = j;
            break;
          end
        end
      end
    end
    for (int i = 0; i < PopSize; i += 2) begin
      pa = pop[sel[i]];
      pb = pop[sel[i+1]];
      if ((next_draw() >> 16) < xover_th) begin
        locus = next_draw() % StringBits;
        mask = 8'((9'd1 << locus) - 9'd1);
        nxt[i] = (pa & mask) | (pb & ~mask);
        nxt[i+1] = (pb & mask) | (pa & ~mask);
      end else begin
        nxt[i] = pa;
        nxt[i+1] = pb;
      end
    end
    for (int i = 0; i < PopSize; i++) pop[i] = nxt[i];
    for (int i = 0; i < PopSize; i++)
      for (int j = 0; j < StringBits; j++)
        if ((next_draw() >> 16) < mut_th) pop[i][j] = ~pop[i][j];
    for (int i = 0; i < PopSize; i++) begin
      m.member_slot = 3'(i);
      m.member_bits = pop[i];
      m.member_fit = popcount8(pop[i]);
      m.all_ones = (pop[i] == 8'hFF);
      m.last_member = (i == PopSize - 1);
      member_fifo.push_back(m);
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      lfsr = SeedReset;
      xover_th <= XoverReset;
      mut_th <= MutReset;
      for (int i = 0; i < PopSize; i++) pop[i] = 0;
      member_fifo.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (member_fifo.size() == 0) begin
          $error("unexpected result item slot %0d", out_data.member_slot);
          fail_count <= fail_count + 1;
        end else begin
          e = member_fifo.pop_front();
          if (out_data != e) begin
            if (out_data.member_slot != e.member_slot)
              $error("member_slot exp %0d got %0d", e.member_slot, out_data.member_slot);
            if (out_data.member_bits != e.member_bits)
              $error("member_bits exp %h got %h", e.member_bits, out_data.member_bits);
            if (out_data.member_fit != e.member_fit)
              $error("member_fit exp %0d got %0d", e.member_fit, out_data.member_fit);
            if (out_data.all_ones != e.all_ones)
              $error("all_ones exp %0d got %0d", e.all_ones, out_data.all_ones);
            if (out_data.last_member != e.last_member)
              $error("last_member exp %0d got %0d", e.last_member, out_data.last_member);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SEED: lfsr = (cfg_data == 0) ? 32'd1 : cfg_data;
          REG_XOVER: xover_th <= cfg_data[15:0];
          REG_MUT: mut_th <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.req_type == REQ_LOAD) pop[in_data.member_index] = in_data.member_value;
        else run_generation();
      end
    end
    pending_members <= member_fifo.size();
  end
endmodule
`default_nettype wire

// ----- verif/genetic_generation_engine_core_tb.sv -----
// testbench top for the one-max generation engine: stimulus and verdict
// depends on gge_pkg, gge_checker and the engine rtl
`timescale 1ns / 100ps
`default_nettype none
module genetic_generation_engine_core_tb;
  import gge_pkg::*;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  int fail_count, pending_members;
  bit quiet_tail;  // no idling on either side near the end

  genetic_generation_engine_core u_top (.*);
  gge_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stalls in random bursts
  initial begin
    int burst;
    out_ready = 0;
    @(posedge clk);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 15);
        out_ready <= 0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  // wait for the result stream to drain, plus slack for the engine to settle
  task automatic drain();
    while (pending_members != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  // one input item; sender gap before it when idling is allowed
  task automatic send_item(logic kind, logic [2:0] slot, logic [7:0] bits);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{req_type: kind, member_index: slot, member_value: bits};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_input();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic load_all_random();
    for (int i = 0; i < PopSize; i++)
      send_item(REQ_LOAD, 3'(i), 8'($urandom));
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = REG_SEED;
    cfg_data = 0;
    quiet_tail = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: zero population run under reset settings, then extremes
    send_item(REQ_RUN, 3'd0, 8'h00);
    for (int i = 0; i < PopSize; i++)
      send_item(REQ_LOAD, 3'(i), (i % 2) ? 8'hFF : 8'h00);
    send_item(REQ_RUN, 3'd7, 8'hFF);
    idle_input();
    drain();  // sender holds off until every result is back

    // zero seed stands in as one; crossover threshold at maximum, no mutation
    write_reg(REG_SEED, 32'd0);
    write_reg(REG_XOVER, 32'hFFFF);
    write_reg(REG_MUT, 32'd0);
    for (int i = 0; i < PopSize; i++) send_item(REQ_LOAD, 3'(i), 8'hFF);
    send_item(REQ_RUN, 3'd0, 8'h00);
    send_item(REQ_LOAD, 3'd3, 8'h01);
    send_item(REQ_RUN, 3'd0, 8'h00);
    idle_input();
    drain();

    // no crossover, mutation threshold at maximum
    write_reg(REG_SEED, 32'hFFFF_FFFF);
    write_reg(REG_XOVER, 32'd0);
    write_reg(REG_MUT, 32'hFFFF);
    send_item(REQ_RUN, 3'd5, 8'hAA);
    idle_input();
    drain();

    // random phases with varied settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_SEED, $urandom);
      write_reg(REG_XOVER, ph == 5 ? 32'd45875 : 32'($urandom_range(0, 65535)));
      write_reg(REG_MUT, ph % 2 ? 32'($urandom_range(0, 4000)) : 32'($urandom_range(0, 65535)));
      if (ph == 5) quiet_tail = 1;
      load_all_random();
      for (int k = 0; k < 17; k++) begin
        if ($urandom_range(0, 2) == 0) send_item(REQ_RUN, 3'($urandom), 8'($urandom));
        else send_item(REQ_LOAD, 3'($urandom), 8'($urandom));
      end
      idle_input();
      drain();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
